### design/silence_run_remover_macros.svh
// Assertion helpers shared by the checker.
`ifndef SILENCE_RUN_REMOVER_MACROS_SVH
`define SILENCE_RUN_REMOVER_MACROS_SVH

// Property checked outside reset.
`define SRR_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("silence_run_remover check failed");

// Property checked at every edge, reset included.
`define SRR_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error("silence_run_remover check failed");

`endif

### design/srr_pkg.sv
`default_nettype none
package srr_pkg;

   localparam int unsigned SAMPLE_W         = 16;
   localparam int unsigned QUIET_W          = 15;
   localparam int unsigned MINLEN_W         = 6;
   localparam int unsigned EFF_W            = 7;
   localparam int unsigned MAX_HELD_RUN_DEF = 32;
   localparam int unsigned CSR_IDX_W        = 1;
   localparam int unsigned CSR_DATA_W       = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_QUIET_LEVEL     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SILENCE_LEN = 1'd1;

   // Configuration seen by the datapath.
   typedef struct packed {
      logic [QUIET_W-1:0] quiet_level;
      logic [EFF_W-1:0]   eff_min;
   } cfg_type;

endpackage
`default_nettype wire

### design/srr_ram.sv
`default_nettype none
module srr_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 32,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### design/srr_cfg.sv
`default_nettype none
module srr_cfg #(
   parameter int unsigned MAX_HELD_RUN = srr_pkg::MAX_HELD_RUN_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            wr_en,
   input  wire logic [srr_pkg::CSR_IDX_W-1:0]   wr_index,
   input  wire logic [srr_pkg::CSR_DATA_W-1:0]  wr_data,
   output srr_pkg::cfg_type                     cfg
);

   localparam logic [srr_pkg::EFF_W-1:0] MIN_CAP = srr_pkg::EFF_W'(MAX_HELD_RUN + 1);

   logic [srr_pkg::QUIET_W-1:0]  quiet_level_ff;
   logic [srr_pkg::MINLEN_W-1:0] min_len_ff;
   logic [srr_pkg::EFF_W-1:0]    min_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         quiet_level_ff <= '0;
         min_len_ff     <= srr_pkg::MINLEN_W'(1);
      end else if (wr_en) begin
         case (wr_index)
            srr_pkg::CSR_QUIET_LEVEL:
               quiet_level_ff <= wr_data[srr_pkg::QUIET_W-1:0];
            srr_pkg::CSR_MIN_SILENCE_LEN:
               min_len_ff <= wr_data[srr_pkg::MINLEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the minimum run length to 1 .. buffer depth + 1.
   always_comb begin
      min_ext         = srr_pkg::EFF_W'(min_len_ff);
      cfg.quiet_level = quiet_level_ff;
      if (min_len_ff == '0) begin
         cfg.eff_min = srr_pkg::EFF_W'(1);
      end else if (min_ext > MIN_CAP) begin
         cfg.eff_min = MIN_CAP;
      end else begin
         cfg.eff_min = min_ext;
      end
   end

endmodule
`default_nettype wire

### design/silence_run_remover.sv
// Timing: a result not read from the run memory passes the tail register, then the output
//   register; a released run passes the memory output register and the output register,
//   one memory read and one result per cycle while the output is free; loud sample last.
// Throughput: 1 item per cycle while no result is caused; none while a run or tail result is going out.
// Reset: synchronous, active high; clears control state, run count, dropping flag and
//   registers (quiet_level = 0, min_silence_len = 1). The run memory is not cleared.
`default_nettype none
module silence_run_remover #(
   parameter int unsigned MAX_HELD_RUN = srr_pkg::MAX_HELD_RUN_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // input items
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [srr_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  wire logic                                  req_stream_end,
   // result items
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [srr_pkg::SAMPLE_W-1:0]        rsp_sample_out,
   output logic                                       rsp_run_last,
   output logic                                       rsp_end_marker,
   // configuration writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [srr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [srr_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int unsigned CNT_W = $clog2(MAX_HELD_RUN + 2);
   localparam int unsigned AW    = (MAX_HELD_RUN > 1) ? $clog2(MAX_HELD_RUN) : 1;
   localparam int unsigned SW    = srr_pkg::SAMPLE_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FLUSH = 3'b010,
      ST_TAIL  = 3'b100
   } state_type;

   srr_pkg::cfg_type cfg;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic [CNT_W-1:0] flush_n_ff, flush_n_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             rd_last_ff, rd_last_in;
   logic             tail_pend_ff, tail_pend_in;
   logic [SW-1:0]    tail_sample_ff, tail_sample_in;
   logic             tail_endm_ff, tail_endm_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]    rsp_sample_ff, rsp_sample_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_endm_ff, rsp_endm_in;

   logic             accept;
   logic             out_free;
   logic             load_rd;
   logic             issue;
   logic [SW:0]      mag;
   logic             quiet;
   logic [CNT_W-1:0] cnt_inc;
   logic             run_full;
   logic             mem_we;
   logic [SW-1:0]    rd_data;

   // configuration registers
   assign csr_ready = 1'b1;

   srr_cfg #(
      .MAX_HELD_RUN (MAX_HELD_RUN)
   ) u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // handshakes: take a new item only when idle, with no release or tail result in progress
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   // classify: magnitude of -32768 is 32768
   always_comb begin
      if (req_sample_in[SW-1]) begin
         mag = (SW+1)'(1 << SW) - {1'b0, req_sample_in};
      end else begin
         mag = {1'b0, req_sample_in};
      end
      quiet    = (mag <= (SW+1)'(cfg.quiet_level));
      cnt_inc  = count_ff + CNT_W'(1);
      run_full = (srr_pkg::EFF_W'(cnt_inc) >= cfg.eff_min);
   end

   // hold a quiet sample at the end of the run unless the run is being dropped or the buffer is full
   assign mem_we = accept & quiet & ~drop_ff & (count_ff < CNT_W'(MAX_HELD_RUN));

   // release pipeline: one read in flight, data held in the memory output register
   assign load_rd = (state_ff == ST_FLUSH) & rd_vld_ff & out_free;
   assign issue   = (state_ff == ST_FLUSH) & (idx_ff < flush_n_ff) & (~rd_vld_ff | load_rd);

   srr_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_HELD_RUN)
   ) u_run_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_sample_in),
      .rd_en   (issue),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      drop_in        = drop_ff;
      flush_n_in     = flush_n_ff;
      idx_in         = idx_ff;
      rd_vld_in      = rd_vld_ff;
      rd_last_in     = rd_last_ff;
      tail_pend_in   = tail_pend_ff;
      tail_sample_in = tail_sample_ff;
      tail_endm_in   = tail_endm_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_sample_in  = rsp_sample_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_endm_in    = rsp_endm_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in         = '0;
               rd_vld_in      = 1'b0;
               tail_pend_in   = 1'b0;
               tail_sample_in = req_sample_in;
               tail_endm_in   = 1'b0;
               flush_n_in     = '0;
               if (quiet) begin
                  if (!drop_ff) begin
                     if (run_full) begin
                        // run reached the minimum: drop it and what follows
                        count_in = '0;
                        drop_in  = 1'b1;
                     end else begin
                        count_in = cnt_inc;
                     end
                  end
                  if (req_stream_end) begin
                     if (drop_ff || run_full) begin
                        tail_pend_in   = 1'b1;
                        tail_sample_in = '0;
                        tail_endm_in   = 1'b1;
                     end else begin
                        flush_n_in = cnt_inc;
                     end
                  end
               end else begin
                  // loud: release the held run, then pass the sample
                  flush_n_in   = count_ff;
                  tail_pend_in = 1'b1;
                  count_in     = '0;
                  drop_in      = 1'b0;
               end
               if (req_stream_end) begin
                  count_in = '0;
                  drop_in  = 1'b0;
               end
               if (flush_n_in != '0) begin
                  state_in = ST_FLUSH;
               end else if (tail_pend_in) begin
                  state_in = ST_TAIL;
               end
            end
         end

         ST_FLUSH: begin
            if (issue) begin
               idx_in     = idx_ff + CNT_W'(1);
               rd_last_in = (idx_ff + CNT_W'(1) == flush_n_ff);
               rd_vld_in  = 1'b1;
            end else if (load_rd) begin
               rd_vld_in = 1'b0;
            end
            if (load_rd) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = rd_data;
               rsp_last_in   = rd_last_ff & ~tail_pend_ff;
               rsp_endm_in   = 1'b0;
               if (rd_last_ff) begin
                  state_in = tail_pend_ff ? ST_TAIL : ST_IDLE;
               end
            end
         end

         ST_TAIL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = tail_sample_ff;
               rsp_last_in   = 1'b1;
               rsp_endm_in   = tail_endm_ff;
               tail_pend_in  = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rd_vld_ff    <= 1'b0;
         tail_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rd_vld_ff    <= rd_vld_in;
         tail_pend_ff <= tail_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and loop bookkeeping
   always_ff @(posedge clock) begin
      flush_n_ff     <= flush_n_in;
      idx_ff         <= idx_in;
      rd_last_ff     <= rd_last_in;
      tail_sample_ff <= tail_sample_in;
      tail_endm_ff   <= tail_endm_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_endm_ff    <= rsp_endm_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_end_marker = rsp_endm_ff;

endmodule
`default_nettype wire

### design/srr_checker.sv
`default_nettype none
`include "silence_run_remover_macros.svh"
module srr_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [srr_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input wire logic                                rsp_run_last,
   input wire logic                                rsp_end_marker
);

   // a stalled result keeps its payload
   `SRR_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out) && $stable(rsp_run_last) && $stable(rsp_end_marker))

   // an end marker carries no sample and closes its item
   `SRR_ASSERT(a_endm_shape, rsp_valid && rsp_end_marker |-> rsp_run_last && rsp_sample_out == '0)

   // no result right after reset
   `SRR_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid)

   // while a released run is still going out, no new item is taken
   `SRR_ASSERT(a_no_take_mid_run, rsp_valid && !rsp_run_last |-> !req_ready)

endmodule

bind silence_run_remover srr_checker u_srr_checker (.*);
`default_nettype wire

### dv/srr_tb_pkg.sv
`timescale 1ns / 1ps
package srr_tb_pkg;
   import srr_pkg::*;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       run_last;
      logic                       end_marker;
   } kept_item_type;

   // Tracks the silence-removal state and the queue of samples the block must emit.
   class kept_sample_board;
      int unsigned                quiet_level;
      int unsigned                min_len;
      logic signed [SAMPLE_W-1:0] held [MAX_HELD_RUN_DEF];
      int unsigned                held_cnt;
      bit                         dropping;
      logic signed [SAMPLE_W-1:0] out_q [$];
      kept_item_type              kept_q [$];
      int unsigned                n_errors;

      function new();
         quiet_level = 0;
         min_len     = 1;
         held_cnt    = 0;
         dropping    = 1'b0;
         n_errors    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_QUIET_LEVEL) begin
            quiet_level = data[QUIET_W-1:0];
         end else begin
            min_len = data[MINLEN_W-1:0];
         end
      endfunction

      // Zero acts as one; anything past the buffer acts as buffer depth plus one.
      function int unsigned eff_min();
         if (min_len == 0) return 1;
         if (min_len > MAX_HELD_RUN_DEF + 1) return MAX_HELD_RUN_DEF + 1;
         return min_len;
      endfunction

      function void release_run();
         for (int unsigned j = 0; j < held_cnt && j < MAX_HELD_RUN_DEF; j++) begin
            out_q = {out_q, held[j]};
         end
         held_cnt = 0;
      endfunction

      function void take_sample(logic signed [SAMPLE_W-1:0] s, logic stream_end);
         int            mag;
         bit            marker;
         kept_item_type k;
         out_q.delete();
         marker = 1'b0;
         mag = int'(s);
         if (mag < 0) mag = -mag;
         if (mag <= int'(quiet_level)) begin
            if (!dropping) begin
               if (held_cnt < MAX_HELD_RUN_DEF) held[held_cnt] = s;
               held_cnt++;
               if (held_cnt >= eff_min()) begin
                  held_cnt = 0;
                  dropping = 1'b1;
               end
            end
            if (stream_end) begin
               if (dropping) marker = 1'b1;
               else release_run();
            end
         end else begin
            release_run();
            dropping = 1'b0;
            out_q = {out_q, s};
         end
         if (stream_end) begin
            held_cnt = 0;
            dropping = 1'b0;
         end
         if (marker) begin
            k.sample     = '0;
            k.run_last   = 1'b1;
            k.end_marker = 1'b1;
            kept_q = {kept_q, k};
         end
         for (int j = 0; j < out_q.size(); j++) begin
            k.sample     = out_q[j];
            k.run_last   = (j == out_q.size() - 1);
            k.end_marker = 1'b0;
            kept_q = {kept_q, k};
         end
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("ERROR: %s: got %0d, expected %0d", what, got, want);
         n_errors++;
      endtask

      task check_kept(logic signed [SAMPLE_W-1:0] sample, logic run_last,
                      logic end_marker);
         kept_item_type want;
         if (kept_q.size() == 0) begin
            report_mismatch("item with nothing pending, sample_out", int'(sample), 0);
            return;
         end
         want = kept_q.pop_front();
         if (sample !== want.sample)
            report_mismatch("sample_out", int'(sample), int'(want.sample));
         if (run_last !== want.run_last)
            report_mismatch("run_last", int'(run_last), int'(want.run_last));
         if (end_marker !== want.end_marker)
            report_mismatch("end_marker", int'(end_marker), int'(want.end_marker));
      endtask
   endclass

endpackage

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import srr_pkg::*;
   import srr_tb_pkg::*;

   // Cycles with no handshake on any channel before the run is declared hung.
   localparam int unsigned HANG_LIMIT  = 3000;
   // Idle cycles granted after the last result: covers the registered output path
   // plus any quiet item still being absorbed.
   localparam int unsigned SETTLE      = 50;
   localparam int unsigned PHASES      = 5;
   localparam int unsigned PH_QL  [PHASES] = '{32767, 0, 5000, 1000, 12000};
   localparam int unsigned PH_MIN [PHASES] = '{33, 0, 63, 2, 1};
   localparam int unsigned PH_SND [PHASES] = '{0, 53, 0, 35, 0};
   localparam int unsigned PH_RCV [PHASES] = '{0, 0, 53, 35, 0};

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       req_stream_end = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_run_last;
   logic                       rsp_end_marker;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   int unsigned      send_idle_pct = 0;
   int unsigned      rsp_stall_pct = 0;
   int unsigned      hold_left = 0;
   kept_sample_board sb;

   silence_run_remover u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .req_stream_end (req_stream_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_run_last   (rsp_run_last),
      .rsp_end_marker (rsp_end_marker),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: stall at the phase rate, or hold off entirely while a
   // back-pressure stretch is counting down.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Check every result accepted outside reset against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_kept(rsp_sample_out, rsp_run_last, rsp_end_marker);
   end

   // Watchdog: count cycles in which no channel moves an item.
   initial begin : watchdog
      int unsigned still;
      still = 0;
      while (still < HANG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            still = 0;
         else
            still++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Offer one item after idle cycles drawn at the phase rate, and hold it until accepted.
   // Valid is left high on accept; the caller drops it when the stream pauses.
   task automatic send_item(logic signed [SAMPLE_W-1:0] s, logic stream_end);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_sample_in  <= s;
      req_stream_end <= stream_end;
      do @(posedge clock); while (!req_ready);
      sb.take_sample(s, stream_end);
   endtask

   // Write one register; upper data bits are random and must be ignored.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'($urandom);
      if (idx == CSR_QUIET_LEVEL)
         data[QUIET_W-1:0] = value[QUIET_W-1:0];
      else
         data[MINLEN_W-1:0] = value[MINLEN_W-1:0];
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   task automatic drain();
      while (sb.kept_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Reprogram only once the block has gone quiet.
   task automatic configure(int unsigned level, int unsigned min_len);
      drain();
      write_csr(CSR_QUIET_LEVEL, level);
      write_csr(CSR_MIN_SILENCE_LEN, min_len);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] quiet_sample();
      int m;
      m = $urandom_range(sb.quiet_level, 0);
      if ($urandom_range(1)) m = -m;
      return SAMPLE_W'(m);
   endfunction

   // A loud sample; -32768 is the only one left when the level is at its top.
   function automatic logic signed [SAMPLE_W-1:0] loud_sample();
      int m;
      if (sb.quiet_level >= 32767) return 16'sh8000;
      m = $urandom_range(32768, sb.quiet_level + 1);
      if (m == 32768) return 16'sh8000;
      if ($urandom_range(1)) m = -m;
      return SAMPLE_W'(m);
   endfunction

   // Mostly well-formed quiet runs around the removal length closed by a loud
   // sample or an end of stream, with some raw noise mixed in.
   task automatic run_phase(int unsigned n_items);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 12) begin
            send_item(SAMPLE_W'($urandom), ($urandom_range(9) == 0));
            sent++;
         end else begin
            len = $urandom_range(sb.eff_min() + 2, 0);
            for (int unsigned j = 0; j < len; j++) send_item(quiet_sample(), 1'b0);
            if ($urandom_range(99) < 25)
               send_item(quiet_sample(), 1'b1);
            else
               send_item(loud_sample(), ($urandom_range(7) == 0));
            sent += len + 1;
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset registers: level 0, length 1. Only zero is quiet and drops at once,
      // so a quiet end of stream gives an end marker.
      send_item(16'sd0, 1'b1);
      send_item(16'sd1, 1'b0);
      req_valid <= 1'b0;

      configure(100, 3);
      send_item(16'sd32767, 1'b0);    // loud extremes
      send_item(-16'sd32768, 1'b0);
      send_item(16'sd0, 1'b0);        // hold a short run of two
      send_item(16'sd100, 1'b0);      // level itself is quiet
      send_item(16'sd101, 1'b0);      // release the run, then the loud sample
      send_item(-16'sd100, 1'b0);     // run reaches three: drop it
      send_item(-16'sd99, 1'b0);
      send_item(16'sd1, 1'b0);
      send_item(-16'sd3, 1'b0);       // dropped while dropping
      send_item(-16'sd101, 1'b0);     // loud ends dropping
      send_item(16'sd7, 1'b0);        // end of stream on a held run
      send_item(-16'sd7, 1'b1);
      send_item(16'sd0, 1'b0);        // end of stream while dropping
      send_item(16'sd0, 1'b0);
      send_item(16'sd0, 1'b0);
      send_item(16'sd50, 1'b1);
      send_item(-16'sd1, 1'b1);       // fresh stream: single held sample flushed
      send_item(16'sd200, 1'b1);      // loud end of stream
      send_item(16'sh5555, 1'b0);
      send_item(16'shAAAA, 1'b0);
      send_item(16'sd0, 1'b0);
      send_item(16'sd0, 1'b1);
      req_valid <= 1'b0;

      // Random phases: sweep level and length extremes, including zero length
      // and lengths past the buffer, each under its own phase's idling mix.
      for (int unsigned p = 0; p < PHASES; p++) begin
         configure(PH_QL[p], PH_MIN[p]);
         send_idle_pct = PH_SND[p];
         rsp_stall_pct = PH_RCV[p];
         run_phase(8);
      end

      // Back-pressure: hold the receiver off while loud items keep coming,
      // so the block fills and stalls its input.
      configure(300, 34);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_left = 200;
      for (int unsigned j = 0; j < 15; j++) send_item(loud_sample(), ($urandom_range(5) == 0));
      req_valid <= 1'b0;

      drain();
      if (sb.n_errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### files.f
+incdir+design
design/srr_pkg.sv
design/srr_ram.sv
design/srr_cfg.sv
design/silence_run_remover.sv
design/srr_checker.sv
dv/srr_tb_pkg.sv
dv/tb_top.sv
